/* design/i2c_master_bit_engine_assert.svh */
`ifndef I2C_MASTER_BIT_ENGINE_ASSERT_SVH
`define I2C_MASTER_BIT_ENGINE_ASSERT_SVH

// Condition that must hold at every clock edge outside reset
`define I2CBE_ASSERT_ALWAYS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// Antecedent at one edge requires the consequent at the next edge
`define I2CBE_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* design/i2cbe_pkg.sv */
`timescale 1ns / 1ps

package i2cbe_pkg;

   // Command codes carried in the op field; an op of seven is a plain tick
   typedef enum logic [2:0] {
      CMD_IDLE,
      CMD_START,
      CMD_STOP,
      CMD_WRITE,
      CMD_WAITACK,
      CMD_READ,
      CMD_SENDACK
   } cmd_type;

   localparam int unsigned BYTE_W    = 8;
   localparam int unsigned BYTE_MSB  = BYTE_W - 1;
   localparam logic [3:0]  BIT_COUNT = 4'(BYTE_W);

   localparam int unsigned REQ_TDATA_W = 16;
   localparam int unsigned REQ_TUSER_W = 3;
   localparam int unsigned RSP_TDATA_W = 16;

   typedef struct packed {
      logic [15:0] phase_ticks;
      logic [15:0] ack_retry_limit;
      logic [7:0]  stretch_limit;
   } cfg_type;

   typedef struct packed {
      logic [2:0] op;
      logic [7:0] tx_byte;
      logic       ack_level;
      logic       sda_in;
      logic       scl_in;
   } req_type;

   typedef struct packed {
      logic       scl_drive;
      logic       sda_drive;
      logic       busy_res;
      logic       done_res;
      logic [7:0] rx_byte;
      logic       ack_seen;
      logic       ack_timeout;
      logic       rejected;
   } rsp_type;

   // Reload value of the hold counter; zero ticks behaves as one
   function automatic logic [15:0] hold_value(input logic [15:0] ticks);
      hold_value = (ticks == 16'd0) ? 16'd0 : ticks - 16'd1;
   endfunction

endpackage

/* design/i2cbe_csr.sv */
`timescale 1ns / 1ps

module i2cbe_csr (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [3:0]            csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready,
   output i2cbe_pkg::cfg_type    cfg
);
   import i2cbe_pkg::*;

   localparam logic [1:0] REG_PHASE_TICKS = 2'd0;
   localparam logic [1:0] REG_ACK_RETRY   = 2'd1;
   localparam logic [1:0] REG_STRETCH     = 2'd2;

   localparam logic [15:0] PHASE_TICKS_RST = 16'd1;
   localparam logic [15:0] ACK_RETRY_RST   = 16'd100;
   localparam logic [7:0]  STRETCH_RST     = 8'd50;

   logic [15:0] phase_ticks_ff;
   logic [15:0] ack_retry_ff;
   logic [7:0]  stretch_ff;
   logic        wr_en;
   logic [1:0]  reg_idx;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign reg_idx    = csr_paddr[3:2];

   // register writes; unknown indexes are ignored
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ticks_ff <= PHASE_TICKS_RST;
         ack_retry_ff   <= ACK_RETRY_RST;
         stretch_ff     <= STRETCH_RST;
      end else if (wr_en) begin
         unique case (reg_idx)
            REG_PHASE_TICKS: phase_ticks_ff <= csr_pwdata[15:0];
            REG_ACK_RETRY:   ack_retry_ff   <= csr_pwdata[15:0];
            REG_STRETCH:     stretch_ff     <= csr_pwdata[7:0];
            default: ;
         endcase
      end
   end

   // read mux
   always_comb begin
      unique case (reg_idx)
         REG_PHASE_TICKS: csr_prdata = {16'd0, phase_ticks_ff};
         REG_ACK_RETRY:   csr_prdata = {16'd0, ack_retry_ff};
         REG_STRETCH:     csr_prdata = {24'd0, stretch_ff};
         default:         csr_prdata = 32'd0;
      endcase
   end

   assign cfg.phase_ticks     = phase_ticks_ff;
   assign cfg.ack_retry_limit = ack_retry_ff;
   assign cfg.stretch_limit   = stretch_ff;

endmodule

/* design/i2cbe_engine.sv */
`timescale 1ns / 1ps

module i2cbe_engine (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step_en,
   input  i2cbe_pkg::cfg_type    cfg,
   input  i2cbe_pkg::req_type    item,
   output i2cbe_pkg::rsp_type    result
);
   import i2cbe_pkg::*;

   cmd_type     cmd_ff, cmd_in;
   logic [1:0]  phase_ff, phase_in;
   logic [3:0]  bit_ff, bit_in;
   logic [7:0]  shift_ff, shift_in;
   logic [15:0] delay_ff, delay_in;
   logic [15:0] poll_ff, poll_in;
   logic        scl_ff, scl_in;
   logic        sda_ff, sda_in;
   logic        ack_seen_ff, ack_seen_in;
   logic        ack_to_ff, ack_to_in;
   logic [7:0]  rx_ff, rx_in;
   logic        done;
   logic        reject;

   logic        idle;
   logic        is_cmd;
   logic        advance;
   logic [3:0]  bit_inc;
   logic        bit_wrap;
   logic [15:0] hold_val;
   logic [7:0]  shift_up;

   assign idle     = (cmd_ff == CMD_IDLE);
   assign is_cmd   = (item.op >= CMD_START) && (item.op <= CMD_SENDACK);
   assign advance  = !idle && (delay_ff == 16'd0);
   assign bit_inc  = bit_ff + 4'd1;
   assign bit_wrap = (bit_inc >= BIT_COUNT);
   assign hold_val = hold_value(cfg.phase_ticks);
   assign shift_up = {shift_ff[BYTE_MSB-1:0], 1'b0};
   assign reject   = step_en && !idle && is_cmd;

   // next command and phase
   always_comb begin
      cmd_in   = cmd_ff;
      phase_in = phase_ff;
      if (step_en) begin
         if (idle) begin
            if (is_cmd) begin
               cmd_in   = cmd_type'(item.op);
               phase_in = 2'd0;
            end
         end else if (advance) begin
            unique case (cmd_ff)
               CMD_START, CMD_STOP: begin
                  if (phase_ff == 2'd0) phase_in = 2'd1;
                  else begin
                     cmd_in   = CMD_IDLE;
                     phase_in = 2'd0;
                  end
               end
               CMD_WAITACK: begin
                  if (phase_ff == 2'd0) begin
                     if (!item.sda_in) phase_in = 2'd1;
                     else if (poll_ff == 16'd0) begin
                        cmd_in   = CMD_IDLE;
                        phase_in = 2'd0;
                     end
                  end else begin
                     cmd_in   = CMD_IDLE;
                     phase_in = 2'd0;
                  end
               end
               CMD_SENDACK: begin
                  if (phase_ff == 2'd0) phase_in = 2'd1;
                  else if (phase_ff == 2'd1) phase_in = 2'd2;
                  else begin
                     cmd_in   = CMD_IDLE;
                     phase_in = 2'd0;
                  end
               end
               CMD_WRITE: begin
                  if (phase_ff == 2'd0) phase_in = 2'd1;
                  else if (phase_ff == 2'd1) phase_in = 2'd2;
                  else if (bit_wrap) begin
                     cmd_in   = CMD_IDLE;
                     phase_in = 2'd0;
                  end else phase_in = 2'd0;
               end
               CMD_READ: begin
                  if (phase_ff == 2'd0) begin
                     if (item.scl_in || (poll_ff == 16'd0)) phase_in = 2'd1;
                  end else if (bit_wrap) begin
                     cmd_in   = CMD_IDLE;
                     phase_in = 2'd0;
                  end else phase_in = 2'd0;
               end
               default: begin
                  cmd_in   = CMD_IDLE;
                  phase_in = 2'd0;
               end
            endcase
         end
      end
   end

   // line levels, counters, shift data and status
   always_comb begin
      bit_in      = bit_ff;
      shift_in    = shift_ff;
      delay_in    = delay_ff;
      poll_in     = poll_ff;
      scl_in      = scl_ff;
      sda_in      = sda_ff;
      ack_seen_in = ack_seen_ff;
      ack_to_in   = ack_to_ff;
      rx_in       = rx_ff;
      done        = 1'b0;
      if (step_en) begin
         if (idle) begin
            if (is_cmd) begin
               case (cmd_type'(item.op))
                  CMD_START: begin
                     scl_in   = 1'b1;
                     sda_in   = 1'b1;
                     delay_in = hold_val;
                  end
                  CMD_STOP: begin
                     scl_in   = 1'b0;
                     sda_in   = 1'b0;
                     delay_in = hold_val;
                  end
                  CMD_WRITE: begin
                     shift_in = item.tx_byte;
                     bit_in   = 4'd0;
                     scl_in   = 1'b0;
                     sda_in   = item.tx_byte[BYTE_MSB];
                     delay_in = hold_val;
                  end
                  CMD_WAITACK: begin
                     ack_seen_in = 1'b0;
                     ack_to_in   = 1'b0;
                     poll_in     = cfg.ack_retry_limit;
                     scl_in      = 1'b1;
                     sda_in      = 1'b1;
                     delay_in    = hold_val;
                  end
                  CMD_READ: begin
                     shift_in = 8'd0;
                     bit_in   = 4'd0;
                     poll_in  = {8'd0, cfg.stretch_limit};
                     scl_in   = 1'b1;
                     sda_in   = 1'b1;
                     delay_in = 16'd0;
                  end
                  default: begin
                     scl_in   = 1'b0;
                     sda_in   = !item.ack_level;
                     delay_in = hold_val;
                  end
               endcase
            end
         end else if (!advance) begin
            delay_in = delay_ff - 16'd1;
         end else begin
            case (cmd_ff)
               CMD_START: begin
                  if (phase_ff == 2'd0) begin
                     sda_in   = 1'b0;
                     delay_in = hold_val;
                  end else begin
                     scl_in   = 1'b0;
                     delay_in = 16'd0;
                     done     = 1'b1;
                  end
               end
               CMD_STOP: begin
                  if (phase_ff == 2'd0) begin
                     scl_in   = 1'b1;
                     delay_in = hold_val;
                  end else begin
                     sda_in   = 1'b1;
                     delay_in = 16'd0;
                     done     = 1'b1;
                  end
               end
               CMD_WAITACK: begin
                  if (phase_ff == 2'd0) begin
                     if (!item.sda_in) begin
                        ack_seen_in = 1'b1;
                        scl_in      = 1'b0;
                        delay_in    = hold_val;
                     end else if (poll_ff == 16'd0) begin
                        ack_to_in = 1'b1;
                        delay_in  = 16'd0;
                        done      = 1'b1;
                     end else begin
                        poll_in = poll_ff - 16'd1;
                     end
                  end else begin
                     delay_in = 16'd0;
                     done     = 1'b1;
                  end
               end
               CMD_SENDACK: begin
                  if (phase_ff == 2'd0) begin
                     scl_in   = 1'b1;
                     delay_in = hold_val;
                  end else if (phase_ff == 2'd1) begin
                     scl_in   = 1'b0;
                     sda_in   = 1'b1;
                     delay_in = hold_val;
                  end else begin
                     delay_in = 16'd0;
                     done     = 1'b1;
                  end
               end
               CMD_WRITE: begin
                  if (phase_ff == 2'd0) begin
                     scl_in   = 1'b1;
                     delay_in = hold_val;
                  end else if (phase_ff == 2'd1) begin
                     scl_in   = 1'b0;
                     delay_in = hold_val;
                  end else begin
                     bit_in = bit_inc;
                     if (bit_wrap) begin
                        delay_in = 16'd0;
                        done     = 1'b1;
                     end else begin
                        shift_in = shift_up;
                        sda_in   = shift_up[BYTE_MSB];
                        delay_in = hold_val;
                     end
                  end
               end
               CMD_READ: begin
                  if (phase_ff == 2'd0) begin
                     if (item.scl_in || (poll_ff == 16'd0)) begin
                        shift_in = {shift_ff[BYTE_MSB-1:0], item.sda_in};
                        scl_in   = 1'b0;
                     end else begin
                        poll_in = poll_ff - 16'd1;
                     end
                     delay_in = hold_val;
                  end else begin
                     bit_in = bit_inc;
                     if (bit_wrap) begin
                        rx_in    = shift_ff;
                        delay_in = 16'd0;
                        done     = 1'b1;
                     end else begin
                        scl_in   = 1'b1;
                        poll_in  = {8'd0, cfg.stretch_limit};
                        delay_in = 16'd0;
                     end
                  end
               end
               default: begin
                  delay_in = 16'd0;
                  done     = 1'b1;
               end
            endcase
         end
      end
   end

   // engine state
   always_ff @(posedge clock) begin
      if (reset) begin
         cmd_ff      <= CMD_IDLE;
         phase_ff    <= 2'd0;
         bit_ff      <= 4'd0;
         shift_ff    <= 8'd0;
         delay_ff    <= 16'd0;
         poll_ff     <= 16'd0;
         scl_ff      <= 1'b1;
         sda_ff      <= 1'b1;
         ack_seen_ff <= 1'b0;
         ack_to_ff   <= 1'b0;
         rx_ff       <= 8'd0;
      end else begin
         cmd_ff      <= cmd_in;
         phase_ff    <= phase_in;
         bit_ff      <= bit_in;
         shift_ff    <= shift_in;
         delay_ff    <= delay_in;
         poll_ff     <= poll_in;
         scl_ff      <= scl_in;
         sda_ff      <= sda_in;
         ack_seen_ff <= ack_seen_in;
         ack_to_ff   <= ack_to_in;
         rx_ff       <= rx_in;
      end
   end

   // result of this step, taken from the updated state
   assign result.scl_drive   = scl_in;
   assign result.sda_drive   = sda_in;
   assign result.busy_res    = (cmd_in != CMD_IDLE);
   assign result.done_res    = done;
   assign result.rx_byte     = rx_in;
   assign result.ack_seen    = ack_seen_in;
   assign result.ack_timeout = ack_to_in;
   assign result.rejected    = reject;

endmodule

/* design/i2c_master_bit_engine.sv */
`timescale 1ns / 1ps

// I2C master bit engine. Every item on the req channel is one time step of the
// open-drain line sequencer and yields exactly one rsp item with the line drives
// and status after that step. An item may carry a command (start, stop, write,
// wait ack, read, send ack) which is taken only when the engine is idle, else it
// is dropped and flagged as rejected. Throughput is one item per clock while the
// result register is free; an item passes the input register, then the step
// logic into the result register, which holds it until rsp_tready. Hold lengths
// are counted in items, not clocks. Registers are written over the csr_ port;
// the user must write them only while no step is in flight, the block does not enforce it.

module i2c_master_bit_engine (
   input  logic        clock,
   input  logic        reset,
   // req item
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,  // tx_byte[7:0], ack_level[8], sda_in[9], scl_in[10], zero
   input  logic [2:0]  req_tuser,  // op[2:0]
   // rsp item
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,  // scl_drive[0], sda_drive[1], busy_res[2], done_res[3],
                                   // rx_byte[11:4], ack_seen[12], ack_timeout[13],
                                   // rejected[14], zero
   // configuration
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import i2cbe_pkg::*;

   cfg_type     cfg;
   req_type     req_item;
   req_type     in_item_ff;
   logic        in_valid_ff;
   rsp_type     step_rsp;
   rsp_type     rsp_item_ff;
   logic        rsp_valid_ff;
   logic        out_free;
   logic        step_en;

   i2cbe_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // unpack the req item
   assign req_item.op        = req_tuser;
   assign req_item.tx_byte   = req_tdata[7:0];
   assign req_item.ack_level = req_tdata[8];
   assign req_item.sda_in    = req_tdata[9];
   assign req_item.scl_in    = req_tdata[10];

   // pipeline flow: the result register frees when empty or taken
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign step_en    = in_valid_ff && out_free;
   assign req_tready = !in_valid_ff || out_free;

   // input register
   always_ff @(posedge clock) begin
      if (reset) in_valid_ff <= 1'b0;
      else if (req_tready) in_valid_ff <= req_tvalid;
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) in_item_ff <= req_item;
   end

   i2cbe_engine u_engine (
      .clock   (clock),
      .reset   (reset),
      .step_en (step_en),
      .cfg     (cfg),
      .item    (in_item_ff),
      .result  (step_rsp)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (out_free) rsp_valid_ff <= in_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (step_en) rsp_item_ff <= step_rsp;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_item_ff.rejected, rsp_item_ff.ack_timeout,
                        rsp_item_ff.ack_seen, rsp_item_ff.rx_byte, rsp_item_ff.done_res,
                        rsp_item_ff.busy_res, rsp_item_ff.sda_drive, rsp_item_ff.scl_drive};

endmodule

/* design/i2cbe_checker.sv */
`timescale 1ns / 1ps

`include "i2c_master_bit_engine_assert.svh"

module i2cbe_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata
);

   // a stalled result item holds
   `I2CBE_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "rsp item changed while stalled")

   // input only stalls while a finished item waits at the output
   `I2CBE_ASSERT_ALWAYS(a_stall_cause, req_tready || rsp_tvalid, "req stalled with empty output")

   // a completing step leaves the engine idle
   `I2CBE_ASSERT_ALWAYS(a_done_idle, !(rsp_tvalid && rsp_tdata[3] && rsp_tdata[2]), "done while busy")

   // acknowledge and timeout exclude each other
   `I2CBE_ASSERT_ALWAYS(a_ack_excl, !(rsp_tvalid && rsp_tdata[12] && rsp_tdata[13]), "ack seen and timeout together")

endmodule

bind i2c_master_bit_engine i2cbe_checker u_i2cbe_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

/* test/testbench.sv */
`timescale 1ns / 1ps

module testbench;
   import i2cbe_pkg::*;

   // Register indexes on the csr port
   localparam int REG_PHASE_TICKS = 0;
   localparam int REG_ACK_RETRY   = 1;
   localparam int REG_STRETCH     = 2;

   // Op seven is a plain tick that is never rejected
   localparam logic [2:0] OP_ALT_TICK = 3'd7;

   localparam int HOLD_OFF_CYCLES = 60;
   localparam int DRAIN_CYCLES    = 4;
   localparam int STALL_LIMIT     = 4000;
   localparam int PHASE_ITEMS     = 20;
   localparam int NUM_PHASES      = 5;
   localparam int DIR_ROWS        = 18;
   localparam int LONG_HOLD_STEPS = 8;

   localparam rsp_type IDLE_LINES = '{scl_drive: 1'b1, sda_drive: 1'b1, default: '0};

   typedef struct packed {
      logic [2:0] op;
      logic [7:0] tx;
      logic       ackl;
      logic       sda;
      logic       scl;
      logic       run;    // keep ticking until the command completes
      logic       typed;  // expected item given in the row
      rsp_type    exp;
   } dir_row_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [15:0] req_tdata;  // tx_byte[7:0], ack_level[8], sda_in[9], scl_in[10], zero
   logic [2:0]  req_tuser;  // op[2:0]
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [15:0] rsp_tdata;  // scl_drive[0], sda_drive[1], busy_res[2], done_res[3],
                            // rx_byte[11:4], ack_seen[12], ack_timeout[13],
                            // rejected[14], zero
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [3:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   // Configuration copy
   logic [15:0] cfg_phase_ticks = 16'd1;
   logic [15:0] cfg_ack_retry   = 16'd100;
   logic [7:0]  cfg_stretch     = 8'd50;

   // Line sequencer copy
   cmd_type     eng_cmd     = CMD_IDLE;
   logic [2:0]  eng_phase   = '0;
   logic [3:0]  eng_bits    = '0;
   logic [7:0]  eng_shift   = '0;
   logic [15:0] eng_hold    = '0;
   logic [15:0] eng_polls   = '0;
   logic        eng_scl     = 1'b1;
   logic        eng_sda     = 1'b1;
   logic        eng_ack     = 1'b0;
   logic        eng_timeout = 1'b0;
   logic [7:0]  eng_rx      = '0;
   logic        eng_done    = 1'b0;

   rsp_type     line_expected [$];
   int          fail_count      = 0;
   int          stall_cycles    = 0;
   int          sender_idle_pct = 0;
   int          rsp_stall_pct   = 0;
   logic        hold_off_req    = 1'b0;

   int unsigned ph_ticks   [NUM_PHASES] = '{1, 3, 0, 2, 1};
   int unsigned ph_retry   [NUM_PHASES] = '{0, 2, 5, 65535, 100};
   int unsigned ph_stretch [NUM_PHASES] = '{0, 1, 3, 255, 50};
   int          ph_send    [NUM_PHASES] = '{0, 82, 0, 28, 0};
   int          ph_stall   [NUM_PHASES] = '{0, 0, 82, 28, 0};

   dir_row_type dir_table [DIR_ROWS] = '{
      '{CMD_IDLE,    8'h00, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, IDLE_LINES},
      '{OP_ALT_TICK, 8'hFF, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1, IDLE_LINES},
      '{CMD_START,   8'h00, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0, '0},
      '{CMD_STOP,    8'h00, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, '0},
      // a start, then a command while busy, then op seven while busy
      '{CMD_START,   8'h00, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, '0},
      '{CMD_WRITE,   8'h5A, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, '0},
      '{OP_ALT_TICK, 8'h00, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, '0},
      '{CMD_IDLE,    8'h00, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0, '0},
      '{CMD_WRITE,   8'hFF, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0, '0},
      '{CMD_WRITE,   8'h00, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, '0},
      '{CMD_WRITE,   8'hA5, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, '0},
      // ack found, then ack timeout
      '{CMD_WAITACK, 8'h00, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0, '0},
      '{CMD_WAITACK, 8'h00, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0, '0},
      // reads with SCL high, sampling ones then zeros
      '{CMD_READ,    8'h00, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0, '0},
      '{CMD_READ,    8'hFF, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, '0},
      '{CMD_SENDACK, 8'h00, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0, '0},
      '{CMD_SENDACK, 8'h00, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, '0},
      '{CMD_STOP,    8'hFF, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0, '0}
   };

   i2c_master_bit_engine i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Command completes: back to idle with a done pulse
   function automatic void end_command();
      eng_cmd   = CMD_IDLE;
      eng_phase = '0;
      eng_hold  = '0;
      eng_done  = 1'b1;
   endfunction

   // One time step of the line sequencer; returns the lines and status after it
   function automatic rsp_type step_engine(input req_type it);
      rsp_type     r;
      logic        is_cmd;
      logic        rej;
      logic [15:0] reload;
      reload   = (cfg_phase_ticks == 16'd0) ? 16'd0 : cfg_phase_ticks - 16'd1;
      is_cmd   = (it.op != CMD_IDLE) && (it.op != OP_ALT_TICK);
      rej      = 1'b0;
      eng_done = 1'b0;
      if (eng_cmd == CMD_IDLE) begin
         if (is_cmd) begin
            eng_cmd   = cmd_type'(it.op);
            eng_phase = '0;
            case (eng_cmd)
               CMD_START: begin
                  eng_scl = 1'b1; eng_sda = 1'b1; eng_hold = reload;
               end
               CMD_STOP: begin
                  eng_scl = 1'b0; eng_sda = 1'b0; eng_hold = reload;
               end
               CMD_WRITE: begin
                  eng_shift = it.tx_byte; eng_bits = '0;
                  eng_scl = 1'b0; eng_sda = it.tx_byte[BYTE_MSB]; eng_hold = reload;
               end
               CMD_WAITACK: begin
                  eng_ack = 1'b0; eng_timeout = 1'b0; eng_polls = cfg_ack_retry;
                  eng_scl = 1'b1; eng_sda = 1'b1; eng_hold = reload;
               end
               CMD_READ: begin
                  eng_shift = '0; eng_bits = '0; eng_polls = {8'd0, cfg_stretch};
                  eng_scl = 1'b1; eng_sda = 1'b1; eng_hold = '0;
               end
               default: begin
                  eng_scl = 1'b0; eng_sda = ~it.ack_level; eng_hold = reload;
               end
            endcase
         end
      end else begin
         rej = is_cmd;
         if (eng_hold != 16'd0) begin
            eng_hold = eng_hold - 16'd1;
         end else begin
            case (eng_cmd)
               CMD_START: begin
                  if (eng_phase == 3'd0) begin
                     eng_sda = 1'b0; eng_hold = reload; eng_phase = 3'd1;
                  end else begin
                     eng_scl = 1'b0; end_command();
                  end
               end
               CMD_STOP: begin
                  if (eng_phase == 3'd0) begin
                     eng_scl = 1'b1; eng_hold = reload; eng_phase = 3'd1;
                  end else begin
                     eng_sda = 1'b1; end_command();
                  end
               end
               CMD_WAITACK: begin
                  if (eng_phase == 3'd0) begin
                     if (!it.sda_in) begin
                        eng_ack = 1'b1; eng_scl = 1'b0; eng_hold = reload; eng_phase = 3'd1;
                     end else if (eng_polls == 16'd0) begin
                        eng_timeout = 1'b1; end_command();
                     end else begin
                        eng_polls = eng_polls - 16'd1;
                     end
                  end else begin
                     end_command();
                  end
               end
               CMD_SENDACK: begin
                  if (eng_phase == 3'd0) begin
                     eng_scl = 1'b1; eng_hold = reload; eng_phase = 3'd1;
                  end else if (eng_phase == 3'd1) begin
                     eng_scl = 1'b0; eng_sda = 1'b1; eng_hold = reload; eng_phase = 3'd2;
                  end else begin
                     end_command();
                  end
               end
               CMD_WRITE: begin
                  if (eng_phase == 3'd0) begin
                     eng_scl = 1'b1; eng_hold = reload; eng_phase = 3'd1;
                  end else if (eng_phase == 3'd1) begin
                     eng_scl = 1'b0; eng_hold = reload; eng_phase = 3'd2;
                  end else begin
                     eng_bits = eng_bits + 4'd1;
                     if (eng_bits >= BIT_COUNT) begin
                        end_command();
                     end else begin
                        eng_shift = eng_shift << 1;
                        eng_sda   = eng_shift[BYTE_MSB];
                        eng_hold  = reload;
                        eng_phase = 3'd0;
                     end
                  end
               end
               CMD_READ: begin
                  if (eng_phase == 3'd0) begin
                     // sample once SCL is seen high or stretching has run out
                     if (it.scl_in || eng_polls == 16'd0) begin
                        eng_shift = {eng_shift[BYTE_MSB-1:0], it.sda_in};
                        eng_scl = 1'b0; eng_hold = reload; eng_phase = 3'd1;
                     end else begin
                        eng_polls = eng_polls - 16'd1; eng_hold = reload;
                     end
                  end else begin
                     eng_bits = eng_bits + 4'd1;
                     if (eng_bits >= BIT_COUNT) begin
                        eng_rx = eng_shift; end_command();
                     end else begin
                        eng_scl = 1'b1; eng_polls = {8'd0, cfg_stretch};
                        eng_hold = '0; eng_phase = 3'd0;
                     end
                  end
               end
               default: end_command();
            endcase
         end
      end
      r.scl_drive   = eng_scl;
      r.sda_drive   = eng_sda;
      r.busy_res    = (eng_cmd != CMD_IDLE);
      r.done_res    = eng_done;
      r.rx_byte     = eng_rx;
      r.ack_seen    = eng_ack;
      r.ack_timeout = eng_timeout;
      r.rejected    = rej;
      return r;
   endfunction

   function automatic void check_field(input string name, input int unsigned want,
                                       input int unsigned got);
      if (want != got) begin
         $display("%0t ns: %s expected %0h actual %0h", $time, name, want, got);
         fail_count++;
      end
   endfunction

   // Random tick; cmd_pct of them carry a command (or op seven)
   function automatic req_type random_tick(input int sda_pct, input int scl_pct,
                                           input int cmd_pct);
      req_type it;
      if ($urandom_range(99) < cmd_pct)
         it.op = 3'($urandom_range(1, 7));
      else
         it.op = ($urandom_range(9) == 0) ? OP_ALT_TICK : CMD_IDLE;
      it.tx_byte   = 8'($urandom_range(255));
      it.ack_level = 1'($urandom_range(1));
      it.sda_in    = ($urandom_range(99) < sda_pct);
      it.scl_in    = ($urandom_range(99) < scl_pct);
      return it;
   endfunction

   // Offer one item, wait for the handshake, record what it must produce
   task automatic send_step(input req_type it, input logic typed, input rsp_type typed_rsp);
      rsp_type pred;
      while ($urandom_range(99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {5'd0, it.scl_in, it.sda_in, it.ack_level, it.tx_byte};
      req_tuser  <= it.op;
      do @(posedge clock); while (!req_tready);
      pred = step_engine(it);
      line_expected.push_back(typed ? typed_rsp : pred);
      @(negedge clock);
   endtask

   // Stop offering and let every pending result come out
   task automatic drain();
      req_tvalid <= 1'b0;
      while (line_expected.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   // Register write, then read back
   task automatic csr_write(input int idx, input logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr   <= 4'(idx * 4);
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      case (idx)
         REG_PHASE_TICKS: cfg_phase_ticks = value[15:0];
         REG_ACK_RETRY:   cfg_ack_retry   = value[15:0];
         default:         cfg_stretch     = value[7:0];
      endcase
      @(negedge clock);
      csr_pwrite  <= 1'b0;
      csr_penable <= 1'b0;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      check_field("csr readback", value, csr_prdata);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(negedge clock);
   endtask

   // Mostly whole commands with random line levels, some idle noise between
   task automatic run_random(input int budget);
      int      sent;
      int      sda_pct;
      int      scl_pct;
      req_type it;
      sent = 0;
      while (sent < budget) begin
         if ($urandom_range(99) < 15) begin
            repeat ($urandom_range(1, 3)) begin
               send_step(random_tick(50, 50, 0), 1'b0, '0);
               sent++;
            end
         end else begin
            case ($urandom_range(3))
               0:       sda_pct = 0;
               1:       sda_pct = 50;
               2:       sda_pct = 90;
               default: sda_pct = 100;
            endcase
            case ($urandom_range(2))
               0:       scl_pct = 0;
               1:       scl_pct = 30;
               default: scl_pct = 100;
            endcase
            it    = random_tick(sda_pct, scl_pct, 0);
            it.op = 3'($urandom_range(1, 6));
            // keep long limits from turning into endless polling
            if (it.op == CMD_WAITACK && cfg_ack_retry > 16'd200 && sda_pct > 90)
               sda_pct = 90;
            if (it.op == CMD_READ && cfg_stretch > 8'd20 && scl_pct < 30)
               scl_pct = 30;
            send_step(it, 1'b0, '0);
            sent++;
            while (eng_cmd != CMD_IDLE) begin
               send_step(random_tick(sda_pct, scl_pct, 8), 1'b0, '0);
               sent++;
            end
         end
      end
   endtask

   // Receiver: random stalls, plus a long hold-off on request
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_req) begin
            rsp_tready   <= 1'b0;
            hold_off_req <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(negedge clock);
         end else begin
            rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
         end
      end
   end

   // Result checker
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (line_expected.size() == 0) begin
            $display("%0t ns: unexpected item expected none actual %h", $time, rsp_tdata);
            fail_count++;
         end else begin
            want = line_expected.pop_front();
            check_field("scl_drive", want.scl_drive, rsp_tdata[0]);
            check_field("sda_drive", want.sda_drive, rsp_tdata[1]);
            check_field("busy_res", want.busy_res, rsp_tdata[2]);
            check_field("done_res", want.done_res, rsp_tdata[3]);
            check_field("rx_byte", want.rx_byte, rsp_tdata[11:4]);
            check_field("ack_seen", want.ack_seen, rsp_tdata[12]);
            check_field("ack_timeout", want.ack_timeout, rsp_tdata[13]);
            check_field("rejected", want.rejected, rsp_tdata[14]);
         end
      end
   end

   // Watchdog on cycles without any handshake
   always @(posedge clock) begin
      if (reset || csr_psel || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("i2c_master_bit_engine: mismatch");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   // Stimulus
   initial begin
      req_type it;
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tuser   = '0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      repeat (11) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed rows at reset settings
      for (int i = 0; i < DIR_ROWS; i++) begin
         it.op        = dir_table[i].op;
         it.tx_byte   = dir_table[i].tx;
         it.ack_level = dir_table[i].ackl;
         it.sda_in    = dir_table[i].sda;
         it.scl_in    = dir_table[i].scl;
         send_step(it, dir_table[i].typed, dir_table[i].exp);
         if (dir_table[i].run) begin
            it.op = CMD_IDLE;
            while (eng_cmd != CMD_IDLE) send_step(it, 1'b0, '0);
         end
      end
      drain();

      // random phases over several settings and idling patterns
      for (int p = 0; p < NUM_PHASES; p++) begin
         csr_write(REG_PHASE_TICKS, ph_ticks[p]);
         csr_write(REG_ACK_RETRY, ph_retry[p]);
         csr_write(REG_STRETCH, ph_stretch[p]);
         sender_idle_pct = ph_send[p];
         rsp_stall_pct   = ph_stall[p];
         if (p == 0) hold_off_req <= 1'b1;
         run_random(PHASE_ITEMS);
         drain();
      end

      // longest hold: a start command, followed over its first steps
      sender_idle_pct = 0;
      rsp_stall_pct   = 0;
      csr_write(REG_PHASE_TICKS, 32'd65535);
      it = random_tick(100, 100, 0);
      it.op = CMD_START;
      send_step(it, 1'b0, '0);
      it.op = CMD_IDLE;
      repeat (LONG_HOLD_STEPS) send_step(it, 1'b0, '0);
      drain();

      fail_count += line_expected.size();
      if (fail_count == 0)
         $display("i2c_master_bit_engine: match");
      else
         $display("i2c_master_bit_engine: mismatch");
      $finish;
   end

endmodule
